/* rtl/mvn_pkg.sv */
// Package for the mean-variance normalizer.
// Holds the widths, register indexes and controller state type.
// No dependencies.
`timescale 1ns / 1ps

package mvn_pkg;

    localparam int MAX_GROUP  = 64;
    localparam int ADDR_W     = $clog2(MAX_GROUP);
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int DIV_NUM_W  = 39;
    localparam int DIV_DEN_W  = 26;
    localparam int SQRT_IN_W  = 48;
    localparam int SQRT_OUT_W = 24;

    localparam logic REG_NORM_VAR = 1'b0;
    localparam logic REG_EPSILON  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_MEAN_WAIT,
        S_VAR_RD,
        S_VAR_SQ,
        S_VAR_ACC,
        S_VDIV,
        S_VDIV_WAIT,
        S_SQRT,
        S_SQRT_WAIT,
        S_OUT_RD,
        S_OUT_D,
        S_OUT_CALC,
        S_ODIV_WAIT
    } t_state;

endpackage

/* rtl/mvn_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mvn_pkg for its operand widths.
`timescale 1ns / 1ps

module mvn_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mvn_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [mvn_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [mvn_pkg::DIV_NUM_W-1:0]  o_quot
);
    import mvn_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    assign rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
            if (fits) begin
                r_rem <= DIV_DEN_W'(rem_sh - {1'b0, r_den});
            end else begin
                r_rem <= rem_sh[DIV_DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* rtl/mvn_isqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on mvn_pkg for its operand widths.
`timescale 1ns / 1ps

module mvn_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mvn_pkg::SQRT_IN_W-1:0]   i_value,
    output logic                            o_done,
    output logic [mvn_pkg::SQRT_OUT_W-1:0]  o_root
);
    import mvn_pkg::*;

    localparam int STEP_W = $clog2(SQRT_OUT_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [SQRT_IN_W-1:0]  r_val;
    logic [SQRT_OUT_W:0]   r_rem;
    logic [SQRT_OUT_W-1:0] r_root;
    logic [SQRT_OUT_W+2:0] rem_sh;
    logic [SQRT_OUT_W+2:0] trial;
    logic                  fits;

    assign rem_sh = {r_rem, r_val[SQRT_IN_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SQRT_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SQRT_IN_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= (SQRT_OUT_W + 1)'(rem_sh - trial);
                r_root <= {r_root[SQRT_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[SQRT_OUT_W:0];
                r_root <= {r_root[SQRT_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/mean_variance_normalizer.sv */
// Top level of the mean-variance normalizer: sample memory, controller, APB registers.
// Depends on mvn_pkg, mvn_div and mvn_isqrt.
//
// Usage: a sample beat is taken when start is high and busy is low. Samples are
// stored one per cycle in a 64-entry memory until a beat with i_group_end high.
// Beats past 64 samples are dropped, but an end mark among them still closes the group.
// After the end mark, busy stays high while the block computes the mean on the
// shared serial divider, then, with variance scaling on, a sum-of-squares pass
// over the samples, a division and a square root. Each result then takes a
// division, except without variance scaling or with a zero divisor. Results
// appear one beat at a time on o_normalized with o_valid high for one cycle;
// o_result_last marks the final beat. The receiver cannot stall. Reset clears
// the group and sets the variance-scaling flag and epsilon to 1. Registers are at
// byte addresses 0 and 4; the user must write them only while idle (not enforced).
`timescale 1ns / 1ps

module mean_variance_normalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_sample,
    input  logic               i_group_end,
    output logic               o_valid,
    output logic signed [15:0] o_normalized,
    output logic               o_result_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mvn_pkg::*;

    t_state r_state;
    t_state n_state;

    logic                   r_norm_var;
    logic [23:0]            r_eps;
    logic signed [15:0]     r_mem [MAX_GROUP];
    logic signed [15:0]     r_rd_data;
    logic signed [22:0]     r_sum;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       r_idx;
    logic signed [15:0]     r_mean;
    logic [33:0]            r_sq;
    logic [38:0]            r_sumsq;
    logic [24:0]            r_denom;
    logic signed [17:0]     r_d;
    logic                   r_valid;
    logic signed [15:0]     r_norm;
    logic                   r_last;

    logic                   accept;
    logic                   store_en;
    logic                   cfg_wr;
    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;
    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [SQRT_OUT_W-1:0]  sqrt_root;
    logic [21:0]            sum_mag;
    logic signed [17:0]     d_now;
    logic [16:0]            d_now_mag;
    logic [16:0]            d_mag;
    logic                   idx_last;
    logic signed [15:0]     d_sat;
    logic signed [15:0]     q_sat;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign store_en = accept && (r_fill < CNT_W'(MAX_GROUP));
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        if (paddr[2] == REG_EPSILON) begin
            prdata = {8'b0, r_eps};
        end else begin
            prdata = {31'b0, r_norm_var};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_var <= 1'b1;
            r_eps      <= 24'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_EPSILON) begin
                r_eps <= pwdata[23:0];
            end else begin
                r_norm_var <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
    end

    assign sum_mag   = r_sum[22] ? 22'(-r_sum) : r_sum[21:0];
    assign d_now     = 18'(r_rd_data) - 18'(r_mean);
    assign d_now_mag = d_now[17] ? 17'(-d_now) : d_now[16:0];
    assign d_mag     = r_d[17] ? 17'(-r_d) : r_d[16:0];
    assign idx_last  = (r_idx + 1'b1) == r_fill;

    always_comb begin
        if (r_d > 18'sd32767) begin
            d_sat = 16'sh7fff;
        end else if (r_d < -18'sd32768) begin
            d_sat = -16'sh8000;
        end else begin
            d_sat = r_d[15:0];
        end
    end

    always_comb begin
        if (r_d[17]) begin
            q_sat = (div_quot > 39'd32768) ? -16'sh8000 : 16'(-div_quot);
        end else begin
            q_sat = (div_quot > 39'd32767) ? 16'sh7fff : div_quot[15:0];
        end
    end

    always_comb begin
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_num    = DIV_NUM_W'({sum_mag, 1'b0}) + DIV_NUM_W'(r_fill);
        div_den    = DIV_DEN_W'({r_fill, 1'b0});
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_group_end) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                div_start = 1'b1;
                n_state   = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (div_done) begin
                    n_state = r_norm_var ? S_VAR_RD : S_OUT_RD;
                end
            end
            S_VAR_RD: n_state = S_VAR_SQ;
            S_VAR_SQ: n_state = S_VAR_ACC;
            S_VAR_ACC: n_state = idx_last ? S_VDIV : S_VAR_RD;
            S_VDIV: begin
                div_start = 1'b1;
                div_num   = r_sumsq;
                div_den   = DIV_DEN_W'(r_fill);
                n_state   = S_VDIV_WAIT;
            end
            S_VDIV_WAIT: begin
                if (div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                sqrt_start = 1'b1;
                n_state    = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: n_state = S_OUT_D;
            S_OUT_D: n_state = S_OUT_CALC;
            S_OUT_CALC: begin
                div_num = DIV_NUM_W'({d_mag, 17'b0}) + DIV_NUM_W'(r_denom);
                div_den = DIV_DEN_W'({r_denom, 1'b0});
                if (r_norm_var && (r_denom != '0)) begin
                    div_start = 1'b1;
                    n_state   = S_ODIV_WAIT;
                end else begin
                    n_state = idx_last ? S_IDLE : S_OUT_RD;
                end
            end
            S_ODIV_WAIT: begin
                if (div_done) begin
                    n_state = idx_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (store_en) begin
                r_sum  <= r_sum + 23'(i_sample);
                r_fill <= r_fill + 1'b1;
            end
            unique case (r_state)
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        r_idx <= '0;
                    end
                end
                S_VAR_ACC: begin
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                S_OUT_CALC: begin
                    if (!(r_norm_var && (r_denom != '0))) begin
                        r_valid <= 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        if (idx_last) begin
                            r_sum  <= '0;
                            r_fill <= '0;
                        end
                    end
                end
                S_ODIV_WAIT: begin
                    if (div_done) begin
                        r_valid <= 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        if (idx_last) begin
                            r_sum  <= '0;
                            r_fill <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MEAN_WAIT: begin
                r_sumsq <= '0;
                if (div_done) begin
                    r_mean <= r_sum[22] ? 16'(-div_quot) : div_quot[15:0];
                end
            end
            S_VAR_SQ: r_sq <= d_now_mag * d_now_mag;
            S_VAR_ACC: r_sumsq <= r_sumsq + 39'(r_sq);
            S_SQRT_WAIT: r_denom <= 25'(sqrt_root) + 25'(r_eps);
            S_OUT_D: r_d <= d_now;
            S_OUT_CALC: begin
                r_last <= idx_last;
                if (!r_norm_var) begin
                    r_norm <= d_sat;
                end else if (r_d > 18'sd0) begin
                    r_norm <= 16'sh7fff;
                end else if (r_d < 18'sd0) begin
                    r_norm <= -16'sh8000;
                end else begin
                    r_norm <= '0;
                end
            end
            S_ODIV_WAIT: r_norm <= q_sat;
            default: begin
            end
        endcase
    end

    mvn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    mvn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ({div_quot[31:0], 16'b0}),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_valid       = r_valid;
    assign o_normalized  = r_norm;
    assign o_result_last = r_last;

endmodule

/* test/tb_mean_variance_normalizer.sv */
// Self-checking testbench for the mean-variance normalizer: groups of samples in, centered
// and scaled beats out, compared beat by beat against a predictor of the same arithmetic.
// Depends on mvn_pkg and mean_variance_normalizer.
`timescale 1ns / 1ps

module tb_mean_variance_normalizer;
    import mvn_pkg::*;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               group_end;
    } t_sample_beat;

    typedef struct packed {
        logic signed [15:0] normalized;
        logic               result_last;
    } t_norm_beat;

    localparam int CYCLE_LIMIT = 2000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_sample = '0;
    logic               i_group_end = 1'b0;
    logic               o_valid;
    logic signed [15:0] o_normalized;
    logic               o_result_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    mean_variance_normalizer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sample(i_sample), .i_group_end(i_group_end), .o_valid(o_valid),
        .o_normalized(o_normalized), .o_result_last(o_result_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    t_sample_beat pending_beats[$];
    t_norm_beat   expected_beats[$];
    int           gap_lengths[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           sender_on = 1'b0;

    logic signed [15:0] group_samples[$];
    logic signed [22:0] group_sum = '0;
    bit                 scale_on = 1'b1;
    logic [23:0]        eps_value = 24'd1;

    function automatic logic [63:0] round_div(input logic signed [63:0] num,
                                              input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        mag = num < 0 ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitval;
        root = 0;
        bitval = 64'd1 << 62;
        while (bitval > v) bitval >>= 2;
        while (bitval != 0) begin
            if (v >= root + bitval) begin
                v -= root + bitval;
                root = (root >> 1) + bitval;
            end else begin
                root >>= 1;
            end
            bitval >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [63:0] v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    task automatic predict_normalization(input t_sample_beat beat);
        int                 n;
        logic signed [63:0] mean;
        logic signed [63:0] d;
        logic signed [63:0] r;
        logic [63:0]        sumsq;
        logic [63:0]        denom;
        t_norm_beat         res;
        if (group_samples.size() < MAX_GROUP) begin
            group_samples.push_back(beat.sample);
            group_sum = group_sum + 23'(beat.sample);
        end
        if (!beat.group_end) return;
        n = group_samples.size();
        mean = round_div(64'(group_sum), 64'(n));
        denom = 0;
        if (scale_on) begin
            sumsq = 0;
            foreach (group_samples[i]) begin
                d = 64'(group_samples[i]) - mean;
                sumsq += d * d;
            end
            denom = int_sqrt((sumsq / n) << 16) + 64'(eps_value);
        end
        foreach (group_samples[i]) begin
            d = 64'(group_samples[i]) - mean;
            if (!scale_on) r = clamp16(d);
            else if (denom == 0) r = d > 0 ? 32767 : (d < 0 ? -32768 : 0);
            else r = clamp16(round_div(d * 65536, denom));
            res.normalized = r[15:0];
            res.result_last = (i == n - 1);
            expected_beats.push_back(res);
        end
        group_samples.delete();
        group_sum = '0;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] pick_sample(input int shape);
        case (shape)
            0: return 16'($urandom());
            1: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            default: return 16'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    task automatic queue_group(input int len, input int shape);
        t_sample_beat beat;
        for (int k = 0; k < len; k++) begin
            beat.sample = pick_sample(shape);
            beat.group_end = (k == len - 1);
            pending_beats.push_back(beat);
            gap_lengths.push_back(pick_gap());
        end
    endtask

    task automatic queue_beat(input logic signed [15:0] s, input logic e);
        t_sample_beat beat;
        beat.sample = s;
        beat.group_end = e;
        pending_beats.push_back(beat);
        gap_lengths.push_back(0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == {REG_EPSILON, 2'b00}) eps_value = data[23:0];
        else scale_on = data[0];
    endtask

    task automatic run_phase();
        sender_on = 1'b1;
        wait (pending_beats.size() == 0 && !start);
        sender_on = 1'b0;
        wait (expected_beats.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    int  hold_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            predict_normalization('{sample: i_sample, group_end: i_group_end});
            void'(pending_beats.pop_front());
            hold_cycles = gap_lengths.pop_front();
            start <= 1'b0;
        end else if (!start && sender_on && pending_beats.size() != 0) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
            end else begin
                start <= 1'b1;
                i_sample <= pending_beats[0].sample;
                i_group_end <= pending_beats[0].group_end;
            end
        end
    end

    always @(posedge i_clk) begin
        t_norm_beat want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: normalized %0d", o_normalized);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (o_normalized !== want.normalized) begin
                    $error("normalized: expected %0d, got %0d", want.normalized, o_normalized);
                    mismatches++;
                end
                if (o_result_last !== want.result_last) begin
                    $error("result_last: expected %0d, got %0d",
                           want.result_last, o_result_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed groups with the reset register values.
        queue_beat(16'sh7fff, 1'b1);
        queue_beat(-16'sh8000, 1'b0);
        queue_beat(16'sh7fff, 1'b1);
        queue_beat(16'sh0100, 1'b0);
        queue_beat(16'sh0100, 1'b0);
        queue_beat(16'sh0100, 1'b1);
        queue_beat(-16'sh0003, 1'b0);
        queue_beat(16'sh0002, 1'b1);
        run_phase();

        // Epsilon zero: a zero divisor on a constant group, then a spread group.
        apb_write({REG_EPSILON, 2'b00}, 32'd0);
        queue_beat(16'sh0500, 1'b0);
        queue_beat(16'sh0500, 1'b1);
        queue_beat(-16'sh8000, 1'b0);
        queue_beat(16'sh7fff, 1'b1);
        run_phase();

        // An overfull group drops samples past the store depth.
        apb_write({REG_NORM_VAR, 2'b00}, 32'd0);
        queue_group(70, 0);
        queue_beat(-16'sh8000, 1'b0);
        queue_beat(16'sh7fff, 1'b1);
        run_phase();

        apb_write({REG_EPSILON, 2'b00}, 32'hffffff);
        apb_write({REG_NORM_VAR, 2'b00}, 32'd1);
        queue_group(64, 1);
        queue_group(5, 0);
        run_phase();

        for (int phase = 0; phase < 6; phase++) begin
            apb_write({REG_NORM_VAR, 2'b00}, 32'(phase % 3 != 2));
            apb_write({REG_EPSILON, 2'b00},
                      phase == 1 ? 32'd0 : (phase == 4 ? 32'hffffff : $urandom_range(0, 400)));
            for (int g = 0; g < 2; g++)
                queue_group($urandom_range(1, 8), $urandom_range(0, 2));
            run_phase();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
